[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
// expects clk and arst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/stl_parser_pkg.sv]
// types, codes and character helpers for the string to long parser
// used by stl_step, stl_out_stage and string_to_long_parser_core
package stl_parser_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BASE_W   = 6;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned RES_W    = VALUE_W + OFFSET_W + STATUS_W;
	localparam int unsigned TDATA_W  = ((RES_W + 7) / 8) * 8;

	localparam logic [OFFSET_W-1:0] MAX_TEXT_LEN = 16'hffff;
	localparam logic [BASE_W-1:0]   BASE_RESET   = 6'd10;
	localparam logic [BASE_W-1:0]   BASE_MAX     = 6'd36;

	localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7fffffff;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h80000000;

	// parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_PREFIX = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	// digit status
	localparam logic [1:0] DS_NONE = 2'd0;
	localparam logic [1:0] DS_SOME = 2'd1;
	localparam logic [1:0] DS_OVER = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NODIG   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADBASE = 2'd3;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CASE_MASK = 8'hdf;
	localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hff;

	typedef struct packed {
		logic [2:0]          phase;
		logic                neg;
		logic [VALUE_W-1:0]  acc;
		logic [1:0]          dstat;
		logic [BASE_W-1:0]   wbase;
		logic [OFFSET_W-1:0] pos;
	} parse_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] offset;
		logic [VALUE_W-1:0]  value;
	} result_t;

	function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = NO_DIGIT;
		if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
		else if (c >= 8'h41 && c <= 8'h5a) d = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h7a) d = c - 8'h57;
		return d;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

endpackage

[hdl/stl_step.sv]
// one character step of the parser: next state and optional result
// pure combinational, uses stl_parser_pkg
module stl_step (
	input  stl_parser_pkg::parse_state_t              cur,
	input  logic [stl_parser_pkg::CHAR_W-1:0]         char_code,
	input  logic                                      start,
	input  logic [stl_parser_pkg::BASE_W-1:0]         number_base,
	output stl_parser_pkg::parse_state_t              nxt,
	output logic                                      emit,
	output stl_parser_pkg::result_t                   res
);

	logic [stl_parser_pkg::CHAR_W-1:0]  c;
	logic [stl_parser_pkg::CHAR_W-1:0]  d;
	logic                               bad_base;
	logic                               active;
	logic                               do_first;
	logic                               do_take;
	logic [stl_parser_pkg::VALUE_W-1:0] limit;
	logic [stl_parser_pkg::VALUE_W+stl_parser_pkg::BASE_W-1:0] prod;

	assign bad_base = (number_base > stl_parser_pkg::BASE_MAX) || (number_base == 6'd1);

	always_comb begin
		nxt      = cur;
		emit     = 1'b0;
		res      = '0;
		do_first = 1'b0;
		do_take  = 1'b0;
		active   = 1'b0;
		c        = char_code;
		prod     = '0;

		if (start) begin
			nxt.neg   = 1'b0;
			nxt.acc   = '0;
			nxt.dstat = stl_parser_pkg::DS_NONE;
			nxt.pos   = '0;
			nxt.wbase = number_base;
			if (bad_base) begin
				emit       = 1'b1;
				res.status = stl_parser_pkg::ST_BADBASE;
				nxt.phase  = stl_parser_pkg::PH_IDLE;
			end else begin
				nxt.phase = stl_parser_pkg::PH_SPACE;
				active    = 1'b1;
			end
		end else if (cur.phase != stl_parser_pkg::PH_IDLE) begin
			nxt.pos = cur.pos + 16'd1;
			active  = 1'b1;
		end

		// the last index of a long text reads as nul
		if (nxt.pos >= stl_parser_pkg::MAX_TEXT_LEN) c = '0;
		d = stl_parser_pkg::digit_of(c);

		if (active) begin
			unique case (nxt.phase)
				stl_parser_pkg::PH_SPACE: begin
					if (stl_parser_pkg::is_space(c)) begin
						nxt.phase = stl_parser_pkg::PH_SPACE;
					end else if (c == stl_parser_pkg::CH_MINUS ||
						c == stl_parser_pkg::CH_PLUS) begin
						nxt.neg   = (c == stl_parser_pkg::CH_MINUS);
						nxt.phase = stl_parser_pkg::PH_SIGNED;
					end else begin
						do_first = 1'b1;
					end
				end
				stl_parser_pkg::PH_SIGNED: begin
					do_first = 1'b1;
				end
				stl_parser_pkg::PH_ZERO: begin
					if ((c & stl_parser_pkg::CASE_MASK) == stl_parser_pkg::CH_UP_X) begin
						nxt.wbase = 6'd16;
						nxt.phase = stl_parser_pkg::PH_PREFIX;
					end else begin
						if (nxt.wbase == '0) nxt.wbase = 6'd8;
						nxt.phase = stl_parser_pkg::PH_DIGITS;
						do_take   = 1'b1;
					end
				end
				stl_parser_pkg::PH_PREFIX: begin
					// "0x" with no hex digit after it converts the zero alone
					if (d >= 8'd16) begin
						nxt.neg    = 1'b0;
						nxt.phase  = stl_parser_pkg::PH_IDLE;
						emit       = 1'b1;
						res.status = stl_parser_pkg::ST_OK;
						res.offset = nxt.pos - 16'd1;
					end else begin
						nxt.phase = stl_parser_pkg::PH_DIGITS;
						do_take   = 1'b1;
					end
				end
				stl_parser_pkg::PH_DIGITS: begin
					do_take = 1'b1;
				end
				default: begin
					nxt.phase = stl_parser_pkg::PH_IDLE;
				end
			endcase
		end

		if (do_first) begin
			if (c == stl_parser_pkg::CH_ZERO && (nxt.wbase == '0 || nxt.wbase == 6'd16)) begin
				nxt.phase = stl_parser_pkg::PH_ZERO;
				nxt.dstat = stl_parser_pkg::DS_SOME;
			end else begin
				if (nxt.wbase == '0) nxt.wbase = 6'd10;
				nxt.phase = stl_parser_pkg::PH_DIGITS;
				do_take   = 1'b1;
			end
		end

		limit = nxt.neg ? stl_parser_pkg::NEG_LIMIT : stl_parser_pkg::POS_LIMIT;

		if (do_take) begin
			if (d >= {2'b00, nxt.wbase}) begin
				// first character that cannot continue the number
				emit      = 1'b1;
				nxt.phase = stl_parser_pkg::PH_IDLE;
				unique case (nxt.dstat)
					stl_parser_pkg::DS_NONE: begin
						res.status = stl_parser_pkg::ST_NODIG;
					end
					stl_parser_pkg::DS_OVER: begin
						res.status = stl_parser_pkg::ST_RANGE;
						res.offset = nxt.pos;
						res.value  = limit;
					end
					default: begin
						res.status = stl_parser_pkg::ST_OK;
						res.offset = nxt.pos;
						res.value  = nxt.neg ? (32'd0 - nxt.acc) : nxt.acc;
					end
				endcase
			end else if (nxt.dstat != stl_parser_pkg::DS_OVER) begin
				prod = nxt.acc * nxt.wbase + {30'd0, d};
				if (prod > {6'd0, limit}) begin
					nxt.dstat = stl_parser_pkg::DS_OVER;
				end else begin
					nxt.acc   = prod[stl_parser_pkg::VALUE_W-1:0];
					nxt.dstat = stl_parser_pkg::DS_SOME;
				end
			end
		end
	end

endmodule

[hdl/stl_out_stage.sv]
// result register on the master side, loads when empty or while the old result is taken
// uses stl_parser_pkg and assert_macros.svh
`include "assert_macros.svh"

module stl_out_stage (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  stl_parser_pkg::result_t                res,
	output logic                                   ready,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [stl_parser_pkg::TDATA_W-1:0]     m_tdata
);

	logic                    valid_q;
	stl_parser_pkg::result_t res_q;
	logic                    range_res;
	logic                    range_clamped;
	logic                    empty_res;
	logic                    empty_zero;

	// free when empty or when the held request leaves this cycle
	assign ready    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(stl_parser_pkg::TDATA_W - stl_parser_pkg::RES_W){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res;
		end
	end

	assign range_res     = valid_q && (res_q.status == stl_parser_pkg::ST_RANGE);
	assign range_clamped = (res_q.value == stl_parser_pkg::POS_LIMIT) ||
		(res_q.value == stl_parser_pkg::NEG_LIMIT);
	assign empty_res     = valid_q && ((res_q.status == stl_parser_pkg::ST_NODIG) ||
		(res_q.status == stl_parser_pkg::ST_BADBASE));
	assign empty_zero    = (res_q.value == '0) && (res_q.offset == '0);

	`ASSERT_CLK(a_load_needs_room, load |-> ready, "result loaded while stage full")
	`ASSERT_CLK(a_range_clamped, range_res |-> range_clamped, "range error without clamped value")
	`ASSERT_CLK(a_nodig_zero, empty_res |-> empty_zero, "empty result not zero")

endmodule

[hdl/string_to_long_parser_core.sv]
// channel  dir  fields (low bit first)                          handshake
// s        in   tdata: char_code[7:0]; tuser: start_of_text      tvalid/tready
// m        out  tdata: parsed_value[31:0] end_offset[47:32]
//               status[49:48], zero to 56 bits                   tvalid/tready
// base     in   base_wdata: number_base[5:0]                     base_we, no wait
//
// one character is taken per cycle while s_tready is high; state registers hold the parse between characters
// a result is registered and appears in the cycle after the character that ends the text
// input stalls only while a finished result waits on m_tready
// reset clears the parse to idle and the base to 10
// top level of the parser, uses stl_parser_pkg, stl_step, stl_out_stage, assert_macros.svh
`include "assert_macros.svh"

module string_to_long_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tuser,   // start_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // parsed_value[31:0], end_offset[47:32], status[49:48]
	input  logic        base_we,
	input  logic [5:0]  base_wdata // number_base[5:0]
);

	stl_parser_pkg::parse_state_t st_q;
	stl_parser_pkg::parse_state_t st_nxt;
	stl_parser_pkg::result_t      res;
	logic [stl_parser_pkg::BASE_W-1:0] base_q;
	logic emit;
	logic in_acc;
	logic out_ready;
	logic res_load;
	logic st_idle;
	logic bad_start;
	logic bad_shown;

	assign s_tready = out_ready;
	assign in_acc   = s_tvalid && s_tready;
	assign res_load = in_acc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= stl_parser_pkg::BASE_RESET;
		end else if (base_we) begin
			base_q <= base_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= {stl_parser_pkg::PH_IDLE, 1'b0, {stl_parser_pkg::VALUE_W{1'b0}},
				stl_parser_pkg::DS_NONE, {stl_parser_pkg::BASE_W{1'b0}},
				{stl_parser_pkg::OFFSET_W{1'b0}}};
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	stl_step u_step (
		.cur         (st_q),
		.char_code   (s_tdata),
		.start       (s_tuser),
		.number_base (base_q),
		.nxt         (st_nxt),
		.emit        (emit),
		.res         (res)
	);

	stl_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	assign st_idle   = (st_q.phase == stl_parser_pkg::PH_IDLE);
	assign bad_start = in_acc && s_tuser &&
		((base_q > stl_parser_pkg::BASE_MAX) || (base_q == 6'd1));
	assign bad_shown = m_tvalid && (m_tdata[49:48] == stl_parser_pkg::ST_BADBASE);

	`ASSERT_ANY(a_reset_empty, !arst_n |-> !m_tvalid, "result shown during reset")
	`ASSERT_CLK(a_idle_after_emit, res_load |=> st_idle, "parse not idle after result")
	`ASSERT_CLK(a_bad_base, bad_start |=> bad_shown, "invalid base not reported")
	`ASSERT_CLK(a_acc_bound, st_q.acc <= stl_parser_pkg::NEG_LIMIT, "accumulator past limit")

endmodule
